// ===== hdl/sliding_window_mean_inv_stddev_macros.svh =====
// Assertion helpers used by the bound checker in swmis_checker.sv.
`ifndef SLIDING_WINDOW_MEAN_INV_STDDEV_MACROS_SVH
`define SLIDING_WINDOW_MEAN_INV_STDDEV_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWMIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swmis: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWMIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swmis: next-cycle check failed");

`endif

// ===== hdl/swmis_pkg.sv =====
`default_nettype none
package swmis_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_WINDOW  = 1024;
	localparam int WL_W        = 11;
	localparam int PTR_W       = 10;
	localparam int SUM_W       = 26;
	localparam int SQ_W        = 41;
	localparam int PROD_W      = 32;
	localparam int D_W         = 52;
	localparam int ACC_W       = 54;
	localparam int REM_W       = 56;
	localparam int ROOT_W      = 27;
	localparam int MEAN_W      = 32;
	localparam int CNT_W       = 6;

	localparam int MEAN_STEPS  = 42;
	localparam int DIV_STEPS   = 53;
	localparam int SQRT_STEPS  = 27;

	localparam logic [WL_W-1:0]   WL_RESET = 11'd64;
	localparam logic [ROOT_W-1:0] ONE_Q16  = 27'd65536;
	localparam logic [ROOT_W-1:0] INV_MAX  = 27'd67108864;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [WL_W-1:0]               wlen_t;

endpackage
`default_nettype wire

// ===== hdl/sliding_window_mean_inv_stddev.sv =====
// Each sample is absorbed in S_RD, S_UPD1, S_UPD2; a sample that fills the window goes on to
// the mean divide, inverse divide and square root (the last two skipped for a flat window).
// Throughput: one transaction at a time; the next is accepted once the result is in the
// output register. The shared divide/square-root unit (one bit per cycle) sets the rate.
// Reset (arst_n low): window_length = 64, sums, count and pointer cleared, no result.
`default_nettype none
module sliding_window_mean_inv_stddev (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [10:0] cfg_wdata,      // window_length
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
	input  wire logic [0:0]  s_axis_tuser,   // [0] series_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // [31:0] window_mean, [58:32] inverse_stddev
	output logic [0:0]       m_axis_tuser    // [0] flat_window
);
	import swmis_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_UPD1  = 4'd2;
	localparam logic [3:0] S_UPD2  = 4'd3;
	localparam logic [3:0] S_D1    = 4'd4;
	localparam logic [3:0] S_D2    = 4'd5;
	localparam logic [3:0] S_MDIV  = 4'd6;
	localparam logic [3:0] S_MEND  = 4'd7;
	localparam logic [3:0] S_IDIV  = 4'd8;
	localparam logic [3:0] S_SLOAD = 4'd9;
	localparam logic [3:0] S_SQRT  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0]               state_q;
	wlen_t                    wl_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]          sq_q;
	wlen_t                    seen_q;
	logic [PTR_W-1:0]         wp_q;
	logic                     out_valid_q;

	sample_t                  s_q;
	sample_t                  old_q;
	logic                     full_q;
	logic [D_W-1:0]           nsq_q;
	logic [D_W-1:0]           ssq_q;
	logic [D_W-1:0]           d_q;
	logic                     neg_q;
	logic [MEAN_W-1:0]        mean_q;
	logic                     flat_q;
	logic [MEAN_W-1:0]        mean_out_q;
	logic [ROOT_W-1:0]        inv_out_q;
	logic                     flat_out_q;

	// shared divide / square-root unit
	logic [ACC_W-1:0]         acc_q;
	logic [REM_W-1:0]         rem_q;
	logic [ACC_W-1:0]         quo_q;
	logic [D_W-1:0]           dvs_q;
	logic [CNT_W-1:0]         cnt_q;

	sample_t                  line_mem [0:MAX_WINDOW-1];

	wlen_t                    n_eff;
	logic [PTR_W-1:0]         wp_eff;
	logic [WL_W-1:0]          wp_inc;
	logic [PTR_W-1:0]         wp_next;
	sample_t                  mop;
	logic signed [PROD_W-1:0] sq_prod;
	logic signed [D_W-1:0]    ssq_full;
	logic [D_W-1:0]           nsq_full;
	logic [SUM_W-1:0]         abs_sum;
	logic [2*WL_W-1:0]        n_sq;
	logic                     sqrt_mode;
	logic [REM_W-1:0]         shifted;
	logic [REM_W-1:0]         trial;
	logic                     ge;
	logic                     unit_step;
	logic                     unit_last;
	logic [ROOT_W-1:0]        root;
	logic                     out_free;
	logic                     in_xact;

	always_comb begin
		if (wl_q == '0) begin
			n_eff = wlen_t'(1);
		end else if (wl_q > wlen_t'(MAX_WINDOW)) begin
			n_eff = wlen_t'(MAX_WINDOW);
		end else begin
			n_eff = wl_q;
		end
	end

	assign wp_eff  = ({1'b0, wp_q} >= n_eff) ? '0 : wp_q;
	assign wp_inc  = {1'b0, wp_eff} + WL_W'(1);
	assign wp_next = (wp_inc >= n_eff) ? '0 : wp_inc[PTR_W-1:0];

	// one squarer, shared between the new and the leaving sample
	assign mop      = (state_q == S_UPD1) ? s_q : old_q;
	assign sq_prod  = mop * mop;
	assign ssq_full = sum_q * sum_q;
	assign nsq_full = n_eff * sq_q;
	assign abs_sum  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign n_sq     = n_eff * n_eff;

	// restoring step: one quotient bit, or one root bit from two radicand bits
	assign sqrt_mode = (state_q == S_SQRT);
	always_comb begin
		if (sqrt_mode) begin
			shifted = {rem_q[REM_W-3:0], acc_q[ACC_W-1 -: 2]};
			trial   = {{(REM_W-ROOT_W-2){1'b0}}, quo_q[ROOT_W-1:0], 2'b01};
		end else begin
			shifted = {rem_q[REM_W-2:0], acc_q[ACC_W-1]};
			trial   = {{(REM_W-D_W){1'b0}}, dvs_q};
		end
	end
	assign ge        = (shifted >= trial);
	assign unit_step = (state_q == S_MDIV) || (state_q == S_IDIV) || (state_q == S_SQRT);
	assign unit_last = (cnt_q == '0);
	assign root      = quo_q[ROOT_W-1:0];

	// hold off input while a register write lands
	assign s_axis_tready = (state_q == S_IDLE) && !cfg_wen;
	assign in_xact       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wl_q        <= WL_RESET;
			sum_q       <= '0;
			sq_q        <= '0;
			seen_q      <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_wen) begin
						wl_q   <= cfg_wdata;
						sum_q  <= '0;
						sq_q   <= '0;
						seen_q <= '0;
						wp_q   <= '0;
					end else if (in_xact) begin
						if (s_axis_tuser[0]) begin
							sum_q  <= '0;
							sq_q   <= '0;
							seen_q <= '0;
							wp_q   <= '0;
						end
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (seen_q < n_eff) begin
						seen_q <= seen_q + wlen_t'(1);
					end
					wp_q    <= wp_next;
					state_q <= S_UPD1;
				end
				S_UPD1: begin
					sum_q <= sum_q + SUM_W'(s_q) - (full_q ? SUM_W'(old_q) : '0);
					sq_q  <= sq_q + SQ_W'(unsigned'(sq_prod));
					state_q <= S_UPD2;
				end
				S_UPD2: begin
					if (full_q) begin
						sq_q <= sq_q - SQ_W'(unsigned'(sq_prod));
					end
					state_q <= (seen_q >= n_eff) ? S_D1 : S_IDLE;
				end
				S_D1:    state_q <= S_D2;
				S_D2:    state_q <= S_MDIV;
				S_MDIV: begin
					if (unit_last) begin
						state_q <= S_MEND;
					end
				end
				S_MEND:  state_q <= (d_q == '0) ? S_OUT : S_IDIV;
				S_IDIV: begin
					if (unit_last) begin
						state_q <= S_SLOAD;
					end
				end
				S_SLOAD: state_q <= S_SQRT;
				S_SQRT: begin
					if (unit_last) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			old_q           <= line_mem[wp_eff];
			line_mem[wp_eff] <= s_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xact) begin
			s_q <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
		if (state_q == S_RD) begin
			full_q <= (seen_q >= n_eff);
		end
		if (state_q == S_D1) begin
			nsq_q <= nsq_full;
			ssq_q <= unsigned'(ssq_full);
		end
		if (unit_step) begin
			acc_q <= sqrt_mode ? {acc_q[ACC_W-3:0], 2'b00} : {acc_q[ACC_W-2:0], 1'b0};
			rem_q <= ge ? (shifted - trial) : shifted;
			quo_q <= {quo_q[ACC_W-2:0], ge};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		case (state_q)
			S_D2: begin
				d_q   <= nsq_q - ssq_q;
				neg_q <= sum_q[SUM_W-1];
				acc_q <= {abs_sum, {(ACC_W-SUM_W){1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
				dvs_q <= D_W'(n_eff);
				cnt_q <= CNT_W'(MEAN_STEPS - 1);
			end
			S_MEND: begin
				// floor for a negative mean: negate and round the magnitude up
				mean_q <= neg_q
					? MEAN_W'(-(quo_q[MEAN_W-1:0] + MEAN_W'(rem_q != '0)))
					: quo_q[MEAN_W-1:0];
				flat_q <= (d_q == '0);
				acc_q  <= {n_sq[2*WL_W-2:0], 32'b0, 1'b0};
				rem_q  <= '0;
				quo_q  <= '0;
				dvs_q  <= d_q;
				cnt_q  <= CNT_W'(DIV_STEPS - 1);
			end
			S_SLOAD: begin
				acc_q <= quo_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= CNT_W'(SQRT_STEPS - 1);
			end
			S_OUT: begin
				if (out_free) begin
					mean_out_q <= mean_q;
					flat_out_q <= flat_q;
					if (flat_q) begin
						inv_out_q <= ONE_Q16;
					end else if (root > INV_MAX) begin
						inv_out_q <= INV_MAX;
					end else begin
						inv_out_q <= root;
					end
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, inv_out_q, mean_out_q};
	assign m_axis_tuser  = flat_out_q;

endmodule
`default_nettype wire

// ===== hdl/swmis_checker.sv =====
`default_nettype none
`include "sliding_window_mean_inv_stddev_macros.svh"
module swmis_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser
);
	import swmis_pkg::*;

	// a held result stays offered
	`SWMIS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// busy right after taking a transaction
	`SWMIS_ASSERT_NEXT(a_busy_after_in, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// flat window reports exactly 1.0
	`SWMIS_ASSERT_NOW(a_flat_one, clk, arst_n, m_axis_tvalid && m_axis_tuser[0],
		m_axis_tdata[58:32] == ONE_Q16)
	// inverse stddev never exceeds its clamp, padding stays zero
	`SWMIS_ASSERT_NOW(a_inv_range, clk, arst_n, m_axis_tvalid,
		(m_axis_tdata[58:32] <= INV_MAX) && (m_axis_tdata[63:59] == 5'b0))

endmodule

bind sliding_window_mean_inv_stddev swmis_checker u_swmis_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== sim/sliding_window_mean_inv_stddev_checker.sv =====
`timescale 1ns / 1ps

module sliding_window_mean_inv_stddev_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [10:0] cfg_wdata,      // window_length
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
	input  wire logic [0:0]  s_axis_tuser,   // [0] series_start
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [63:0] m_axis_tdata,   // [31:0] window_mean, [58:32] inverse_stddev
	input  wire logic [0:0]  m_axis_tuser,   // [0] flat_window
	output int               mismatches,
	output int               outstanding
);
	import swmis_pkg::*;

	localparam int PRINT_CAP = 100;

	typedef struct {
		logic [MEAN_W-1:0] mean;
		logic [ROOT_W-1:0] inv_sd;
		logic              flat;
	} window_stats_t;

	window_stats_t pending_stats[$];
	wlen_t         window_reg = WL_RESET;
	sample_t       history[MAX_WINDOW];
	longint        sum_acc;
	longint        sq_acc;
	int            fill_count;
	int            slot;

	function automatic int window_span(wlen_t w);
		if (w == 0) begin
			return 1;
		end
		if (w > MAX_WINDOW) begin
			return MAX_WINDOW;
		end
		return int'(w);
	endfunction

	// Build the root one bit at a time from the top.
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		int              b;
		root = 0;
		for (b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v) begin
				root = trial;
			end
		end
		return root;
	endfunction

	function automatic void clear_series();
		sum_acc    = 0;
		sq_acc     = 0;
		fill_count = 0;
		slot       = 0;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
		end
	endtask

	task automatic absorb_sample(input sample_t smp, input logic first);
		int              n;
		longint          num;
		longint          quot;
		longint          dev;
		longint          top_val;
		longint unsigned inv;
		window_stats_t   st;
		n = window_span(window_reg);
		if (first) begin
			clear_series();
		end
		if (slot >= n) begin
			slot = 0;
		end
		// Evict the oldest sample once the window is full.
		if (fill_count >= n) begin
			sum_acc -= history[slot];
			sq_acc  -= longint'(history[slot]) * longint'(history[slot]);
		end else begin
			fill_count++;
		end
		history[slot] = smp;
		sum_acc += smp;
		sq_acc  += longint'(smp) * longint'(smp);
		slot = (slot + 1 >= n) ? 0 : slot + 1;
		if (fill_count < n) begin
			return;
		end

		// Mean rounds toward minus infinity.
		num  = sum_acc * 65536;
		quot = num / n;
		if (num % n != 0 && num < 0) begin
			quot--;
		end
		if (quot > 64'sd2147483647) begin
			quot = 64'sd2147483647;
		end
		if (quot < -64'sd2147483648) begin
			quot = -64'sd2147483648;
		end
		st.mean = quot[MEAN_W-1:0];

		dev = longint'(n) * sq_acc - sum_acc * sum_acc;
		if (dev == 0) begin
			st.inv_sd = ONE_Q16;
			st.flat   = 1'b1;
		end else begin
			top_val = (longint'(n) * n) << 32;
			inv = floor_sqrt(top_val / dev);
			if (inv > INV_MAX) begin
				inv = INV_MAX;
			end
			st.inv_sd = inv[ROOT_W-1:0];
			st.flat   = 1'b0;
		end
		pending_stats = {pending_stats, st};
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		window_stats_t want;
		if (!arst_n) begin
			window_reg = WL_RESET;
			clear_series();
			pending_stats.delete();
		end else begin
			// Retire the output transaction before taking in a new sample.
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_stats.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata, 64'd0);
				end else begin
					want = pending_stats.pop_front();
					if (m_axis_tdata[31:0] !== want.mean) begin
						report_mismatch("window_mean", 64'(m_axis_tdata[31:0]),
							64'(want.mean));
					end
					if (m_axis_tdata[58:32] !== want.inv_sd) begin
						report_mismatch("inverse_stddev", 64'(m_axis_tdata[58:32]),
							64'(want.inv_sd));
					end
					if (m_axis_tuser[0] !== want.flat) begin
						report_mismatch("flat_window", 64'(m_axis_tuser[0]),
							64'(want.flat));
					end
				end
			end
			if (cfg_wen) begin
				window_reg = cfg_wdata;
				clear_series();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_sample(s_axis_tdata, s_axis_tuser[0]);
			end
		end
		outstanding = pending_stats.size();
	end

endmodule

// ===== sim/sliding_window_mean_inv_stddev_test.sv =====
`timescale 1ns / 1ps

module sliding_window_mean_inv_stddev_test;
	import swmis_pkg::*;

	localparam int RUN_LIMIT       = 1_500_000;
	localparam int HOLD_OFF_CYCLES = 700;
	localparam int SETTLE_CYCLES   = 200;

	typedef enum int {RUN_WIDE, RUN_NARROW, RUN_FLAT, RUN_RAILS, RUN_CHOPPY} run_kind_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_wen       = 1'b0;
	wlen_t       cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;   // [15:0] sample
	logic [0:0]  s_axis_tuser  = '0;   // [0] series_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;         // [31:0] window_mean, [58:32] inverse_stddev
	logic [0:0]  m_axis_tuser;         // [0] flat_window

	int        mismatches;
	int        outstanding;
	int        watchdog_cycles;
	bit        jitter       = 1'b1;
	bit        hold_off_req = 1'b0;
	run_kind_t run_kind     = RUN_WIDE;
	int        run_left     = 0;
	sample_t   last_sample  = '0;

	sliding_window_mean_inv_stddev u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	sliding_window_mean_inv_stddev_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		for (watchdog_cycles = 0; watchdog_cycles < RUN_LIMIT; watchdog_cycles++) begin
			@(posedge clk);
		end
		$display("sliding_window_mean_inv_stddev regression: fail");
		$finish;
	end

	// Result sink: random stall bursts, plus one long hold-off on request.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left   = HOLD_OFF_CYCLES;
			end else if (stall_left == 0 && jitter && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one sample and hold it until the transaction completes; returns on a falling edge.
	task automatic push_sample(input sample_t smp, input bit first);
		if (jitter && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tuser  <= first;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Drop valid, drain every pending result, then let the block go idle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_window(input wlen_t w);
		cfg_wen   <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	task automatic random_phase(input wlen_t w, input bit do_write, input int count,
			input int start_odds, input bit pressure, input bit quiet);
		sample_t smp;
		bit      first;
		int      i;
		jitter = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
		if (do_write) begin
			write_window(w);
		end
		for (i = 0; i < count; i++) begin
			if (pressure && i == count / 3) begin
				hold_off_req = 1'b1;
			end
			if (run_left == 0) begin
				// Choppy runs restart often, so keep them out of long windows.
				run_kind = run_kind_t'($urandom_range(0, start_odds < 1000 ? 4 : 3));
				run_left = $urandom_range(1, 40);
			end
			run_left--;
			case (run_kind)
			RUN_WIDE: begin
				smp = sample_t'($urandom);
			end
			RUN_NARROW: begin
				smp = sample_t'(int'($urandom_range(0, 6)) - 3);
			end
			RUN_FLAT: begin
				smp = last_sample;
			end
			RUN_RAILS: begin
				smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			end
			default: begin
				smp = last_sample + sample_t'(int'($urandom_range(0, 4)) - 2);
			end
			endcase
			first = ($urandom_range(0, run_kind == RUN_CHOPPY ? 3 : start_odds) == 0);
			last_sample = smp;
			push_sample(smp, first);
		end
		settle();
	endtask

	initial begin : stimulus
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Window length left at its reset value.
		random_phase(WL_RESET, 1'b0, 100, 400, 1'b0, 1'b0);

		// One-sample window: always flat.
		write_window(11'd1);
		push_sample(sample_t'(32767), 1'b1);
		push_sample(sample_t'(-32768), 1'b0);
		push_sample(sample_t'(0), 1'b0);
		push_sample(sample_t'(-1), 1'b0);
		push_sample(sample_t'(1), 1'b1);
		settle();

		// Two samples: full-scale spread, flat rails, a restart, minimum mean.
		write_window(11'd2);
		push_sample(sample_t'(-32768), 1'b1);
		push_sample(sample_t'(32767), 1'b0);
		push_sample(sample_t'(32767), 1'b0);
		push_sample(sample_t'(5), 1'b1);
		push_sample(sample_t'(6), 1'b0);
		push_sample(sample_t'(-32768), 1'b1);
		push_sample(sample_t'(-32768), 1'b0);
		settle();

		// Three samples: fractional means of both signs.
		write_window(11'd3);
		push_sample(sample_t'(1), 1'b1);
		push_sample(sample_t'(2), 1'b0);
		push_sample(sample_t'(2), 1'b0);
		push_sample(sample_t'(-1), 1'b0);
		push_sample(sample_t'(-2), 1'b1);
		push_sample(sample_t'(-2), 1'b0);
		push_sample(sample_t'(-1), 1'b0);
		settle();

		random_phase(11'd0,    1'b1, 60,   30,      1'b0, 1'b0);
		random_phase(11'd5,    1'b1, 80,   60,      1'b0, 1'b0);
		random_phase(11'd2,    1'b1, 80,   30,      1'b1, 1'b0);
		random_phase(11'd7,    1'b1, 80,   60,      1'b0, 1'b0);
		random_phase(11'd16,   1'b1, 100,  150,     1'b0, 1'b0);
		random_phase(11'd1024, 1'b1, 40,   1000000, 1'b0, 1'b0);
		random_phase(11'd2047, 1'b1, 1060, 1000000, 1'b0, 1'b0);
		random_phase(11'd3,    1'b1, 80,   40,      1'b0, 1'b0);
		random_phase(11'd1,    1'b1, 60,   20,      1'b0, 1'b0);
		random_phase(11'd100,  1'b1, 150,  600,     1'b0, 1'b1);

		if (mismatches == 0 && outstanding == 0) begin
			$display("sliding_window_mean_inv_stddev regression: pass");
		end else begin
			$display("sliding_window_mean_inv_stddev regression: fail");
		end
		$finish;
	end

endmodule
